/* hw/rtl/tcsa_pkg.sv */
// Shared types and codes for the three class slot allocator.
// Used by three_class_slot_allocator_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcsa_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] cls_t;
    typedef logic [2:0] cfg_index_t;

    localparam int SIZE_W      = 48;
    localparam int FIELD_ADDR_W = 48;
    localparam int SLOT_SIZE_W = 32;
    localparam int SLOT_CNT_W  = 10;
    localparam int CFG_DATA_W  = 48;
    localparam int NUM_CLASSES = 3;

    localparam opcode_t OP_ALLOC   = 2'd0;
    localparam opcode_t OP_FREE    = 2'd1;
    localparam opcode_t OP_REBUILD = 2'd2;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_EMPTY   = 2'd1;
    localparam status_t STAT_FULL    = 2'd2;
    localparam status_t STAT_NOMATCH = 2'd3;

    localparam cls_t CLS_LARGE  = 2'd0;
    localparam cls_t CLS_MEDIUM = 2'd1;
    localparam cls_t CLS_SMALL  = 2'd2;

    localparam cfg_index_t REG_BASE         = 3'd0;
    localparam cfg_index_t REG_LARGE_SIZE   = 3'd1;
    localparam cfg_index_t REG_LARGE_COUNT  = 3'd2;
    localparam cfg_index_t REG_MEDIUM_SIZE  = 3'd3;
    localparam cfg_index_t REG_MEDIUM_COUNT = 3'd4;
    localparam cfg_index_t REG_SMALL_SIZE   = 3'd5;
    localparam cfg_index_t REG_SMALL_COUNT  = 3'd6;

endpackage

`default_nettype wire

/* hw/rtl/three_class_slot_allocator_top.sv */
// Three class slot allocator: config registers, slot address memory, control.
// Depends on tcsa_pkg.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready: s_tuser is the opcode (alloc, free,
//   rebuild), s_tdata carries request_size and slot_address. Results leave on
//   m_tvalid/m_tready: m_tdata is granted_address, m_tuser is status.
//   Registers are to be written through cfg_we/cfg_index/cfg_data while idle;
//   the block itself does not enforce it. Alloc, free and no-op: s_tready is
//   high in idle; the item updates the free count and issues at most one memory
//   access in the accept cycle, then the response state loads the result into
//   the output register once it is free. No new item is taken before that.
//   Rebuild: writes the slots of each class in turn (large, medium, small) up to
//   its capped count, then sets its free count; then it loads the result.
//   If the receiver stalls, the result waits in the output register; the block
//   takes one more item and holds its result until the output register frees.
//   Reset clears the registers, the free counts and the handshake state; the
//   slot memory is not cleared (an entry is read only after it was written).
`timescale 1ns / 1ps
`default_nettype none

module three_class_slot_allocator_top #(
    parameter int MAX_SLOTS_PER_CLASS = 512,
    parameter int ADDR_BITS           = 48
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // request_size[47:0], slot_address[95:48]
    input  wire logic [1:0]   s_tuser,   // opcode[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // granted_address[47:0]
    output logic [1:0]        m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(MAX_SLOTS_PER_CLASS + 1);
    localparam int DEPTH = 3 * MAX_SLOTS_PER_CLASS;
    localparam int SAW   = $clog2(DEPTH);
    localparam int LW    = (CNT_W > tcsa_pkg::SLOT_CNT_W) ? CNT_W : tcsa_pkg::SLOT_CNT_W;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RESP    = 2'd1;
    localparam logic [1:0] ST_REBUILD = 2'd2;

    // configuration
    logic [tcsa_pkg::CFG_DATA_W-1:0]  base_reg;
    logic [tcsa_pkg::SLOT_SIZE_W-1:0] size_reg  [tcsa_pkg::NUM_CLASSES];
    logic [tcsa_pkg::SLOT_CNT_W-1:0]  count_reg [tcsa_pkg::NUM_CLASSES];

    // control
    logic [1:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           free_cnt_reg [tcsa_pkg::NUM_CLASSES];
    logic [CNT_W-1:0]           free_cnt_next [tcsa_pkg::NUM_CLASSES];
    tcsa_pkg::status_t          status_reg, status_next;
    logic                       use_rd_reg, use_rd_next;
    tcsa_pkg::cls_t             rb_cls_reg, rb_cls_next;
    logic [CNT_W-1:0]           rb_idx_reg, rb_idx_next;
    logic [ADDR_BITS-1:0]       rb_addr_reg, rb_addr_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [47:0]                m_data_reg, m_data_next;
    tcsa_pkg::status_t          m_status_reg, m_status_next;

    // slot memory
    logic [ADDR_BITS-1:0]       slot_mem [DEPTH];
    logic [ADDR_BITS-1:0]       mem_rdata_reg;
    logic                       mem_we, mem_re;
    logic [SAW-1:0]             mem_waddr, mem_raddr;
    logic [ADDR_BITS-1:0]       mem_wdata;

    // input fields
    tcsa_pkg::opcode_t          s_opcode;
    logic [47:0]                s_size;
    logic [47:0]                s_addr;
    logic                       hit;
    tcsa_pkg::cls_t             hit_cls;
    logic [CNT_W-1:0]           hit_cnt;
    logic [CNT_W-1:0]           rb_lim;

    assign s_opcode = s_tuser;
    assign s_size   = s_tdata[47:0];
    assign s_addr   = s_tdata[95:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    function automatic logic [CNT_W-1:0] limit_count(input logic [tcsa_pkg::SLOT_CNT_W-1:0] n);
        logic [LW-1:0] w;
        w = LW'(n);
        if (w > LW'(MAX_SLOTS_PER_CLASS))
            limit_count = CNT_W'(MAX_SLOTS_PER_CLASS);
        else
            limit_count = CNT_W'(w);
    endfunction

    function automatic logic [SAW-1:0] class_offset(input tcsa_pkg::cls_t c);
        case (c)
            tcsa_pkg::CLS_MEDIUM: class_offset = SAW'(MAX_SLOTS_PER_CLASS);
            tcsa_pkg::CLS_SMALL:  class_offset = SAW'(2 * MAX_SLOTS_PER_CLASS);
            default:              class_offset = '0;
        endcase
    endfunction

    // first class in large, medium, small order whose size matches
    always_comb
    begin
        hit     = 1'b1;
        hit_cls = tcsa_pkg::CLS_LARGE;
        if (s_size == 48'(size_reg[0]))
            hit_cls = tcsa_pkg::CLS_LARGE;
        else if (s_size == 48'(size_reg[1]))
            hit_cls = tcsa_pkg::CLS_MEDIUM;
        else if (s_size == 48'(size_reg[2]))
            hit_cls = tcsa_pkg::CLS_SMALL;
        else
            hit = 1'b0;
        hit_cnt = free_cnt_reg[hit_cls];
        rb_lim  = limit_count(count_reg[rb_cls_reg]);
    end

    always_comb
    begin
        state_next    = state_reg;
        free_cnt_next = free_cnt_reg;
        status_next   = status_reg;
        use_rd_next   = use_rd_reg;
        rb_cls_next   = rb_cls_reg;
        rb_idx_next   = rb_idx_reg;
        rb_addr_next  = rb_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = '0;
        mem_raddr     = '0;
        mem_wdata     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next  = ST_RESP;
                    status_next = tcsa_pkg::STAT_OK;
                    use_rd_next = 1'b0;
                    case (s_opcode)
                        tcsa_pkg::OP_ALLOC:
                        begin
                            if (!hit)
                                status_next = tcsa_pkg::STAT_NOMATCH;
                            else if (hit_cnt == '0)
                                status_next = tcsa_pkg::STAT_EMPTY;
                            else
                            begin
                                mem_re                 = 1'b1;
                                mem_raddr              = class_offset(hit_cls)
                                                         + SAW'(hit_cnt - CNT_W'(1));
                                free_cnt_next[hit_cls] = hit_cnt - CNT_W'(1);
                                use_rd_next            = 1'b1;
                            end
                        end
                        tcsa_pkg::OP_FREE:
                        begin
                            if (!hit)
                                status_next = tcsa_pkg::STAT_NOMATCH;
                            else if (hit_cnt >= limit_count(count_reg[hit_cls]))
                                status_next = tcsa_pkg::STAT_FULL;
                            else
                            begin
                                mem_we                 = 1'b1;
                                mem_waddr              = class_offset(hit_cls) + SAW'(hit_cnt);
                                mem_wdata              = ADDR_BITS'(s_addr);
                                free_cnt_next[hit_cls] = hit_cnt + CNT_W'(1);
                            end
                        end
                        tcsa_pkg::OP_REBUILD:
                        begin
                            state_next   = ST_REBUILD;
                            rb_cls_next  = tcsa_pkg::CLS_LARGE;
                            rb_idx_next  = '0;
                            rb_addr_next = ADDR_BITS'(base_reg);
                        end
                        default: ;
                    endcase
                end
            end
            ST_REBUILD:
            begin
                if (rb_idx_reg < rb_lim)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = class_offset(rb_cls_reg) + SAW'(rb_idx_reg);
                    mem_wdata    = rb_addr_reg;
                    rb_addr_next = rb_addr_reg + ADDR_BITS'(size_reg[rb_cls_reg]);
                    rb_idx_next  = rb_idx_reg + CNT_W'(1);
                end
                else
                begin
                    free_cnt_next[rb_cls_reg] = rb_lim;
                    rb_idx_next               = '0;
                    if (rb_cls_reg == tcsa_pkg::CLS_SMALL)
                        state_next = ST_RESP;
                    else
                        rb_cls_next = rb_cls_reg + 2'd1;
                end
            end
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = use_rd_reg ? 48'(mem_rdata_reg) : 48'd0;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            for (int i = 0; i < tcsa_pkg::NUM_CLASSES; i++)
            begin
                size_reg[i]     <= '0;
                count_reg[i]    <= '0;
                free_cnt_reg[i] <= '0;
            end
            state_reg    <= ST_IDLE;
            status_reg   <= tcsa_pkg::STAT_OK;
            use_rd_reg   <= 1'b0;
            rb_cls_reg   <= tcsa_pkg::CLS_LARGE;
            rb_idx_reg   <= '0;
            rb_addr_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= '0;
            m_status_reg <= tcsa_pkg::STAT_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tcsa_pkg::REG_BASE:         base_reg     <= cfg_data;
                    tcsa_pkg::REG_LARGE_SIZE:   size_reg[0]  <= cfg_data[31:0];
                    tcsa_pkg::REG_LARGE_COUNT:  count_reg[0] <= cfg_data[9:0];
                    tcsa_pkg::REG_MEDIUM_SIZE:  size_reg[1]  <= cfg_data[31:0];
                    tcsa_pkg::REG_MEDIUM_COUNT: count_reg[1] <= cfg_data[9:0];
                    tcsa_pkg::REG_SMALL_SIZE:   size_reg[2]  <= cfg_data[31:0];
                    tcsa_pkg::REG_SMALL_COUNT:  count_reg[2] <= cfg_data[9:0];
                    default: ;
                endcase
            end
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            status_reg   <= status_next;
            use_rd_reg   <= use_rd_next;
            rb_cls_reg   <= rb_cls_next;
            rb_idx_reg   <= rb_idx_next;
            rb_addr_reg  <= rb_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= slot_mem[mem_raddr];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg[0] <= CNT_W'(MAX_SLOTS_PER_CLASS)
        && free_cnt_reg[1] <= CNT_W'(MAX_SLOTS_PER_CLASS)
        && free_cnt_reg[2] <= CNT_W'(MAX_SLOTS_PER_CLASS))
        else $error("free count above class capacity");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, mem_waddr} < (SAW+1)'(DEPTH)))
        else $error("slot memory write out of range");

    a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == ST_RESP) && use_rd_reg)
        else $error("memory read not followed by its result");

    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result loaded outside response state");

endmodule

`default_nettype wire

/* test/three_class_slot_allocator_top_test.sv */
`timescale 1ns / 1ps
// Testbench for three_class_slot_allocator_top: alloc, free and rebuild items, both directed
// and random, checked against a slot-stack predictor. Depends on tcsa_pkg and the top module.

module three_class_slot_allocator_top_test;

    localparam tcsa_pkg::opcode_t OP_NOP      = 2'd3;
    localparam int                MAX_SLOTS   = 512;
    localparam int                NUM_PHASES  = 12;
    localparam int                PHASE_ITEMS = 115;

    typedef struct packed {
        tcsa_pkg::opcode_t op;
        logic [47:0]       req_size;
        logic [47:0]       slot_addr;
    } slot_request_t;

    typedef struct packed {
        logic [47:0]       addr;
        tcsa_pkg::status_t status;
    } slot_grant_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // request_size[47:0], slot_address[95:48]
    logic [1:0]  s_tuser   = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // granted_address[47:0]
    logic [1:0]  m_tuser;          // status[1:0]

    // predictor state
    logic [47:0] base_reg;
    logic [31:0] class_size  [tcsa_pkg::NUM_CLASSES];
    logic [9:0]  class_count [tcsa_pkg::NUM_CLASSES];
    logic [47:0] stack_mem   [tcsa_pkg::NUM_CLASSES][MAX_SLOTS];
    int          free_slots  [tcsa_pkg::NUM_CLASSES];

    slot_request_t request_queue[$];
    slot_grant_t   grant_queue[$];
    int            mismatches    = 0;
    int            send_idle_pct = 26;
    int            recv_idle_pct = 26;

    three_class_slot_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int slot_limit(int c);
        return (class_count[c] > MAX_SLOTS) ? MAX_SLOTS : int'(class_count[c]);
    endfunction

    function automatic int match_class(logic [47:0] req);
        for (int c = 0; c < tcsa_pkg::NUM_CLASSES; c++)
        begin
            if (req == {16'd0, class_size[c]})
                return c;
        end
        return -1;
    endfunction

    function automatic slot_grant_t apply_request(slot_request_t r);
        slot_grant_t g;
        int          c;
        logic [47:0] a;
        g.addr   = '0;
        g.status = tcsa_pkg::STAT_OK;
        case (r.op)
            tcsa_pkg::OP_ALLOC:
            begin
                c = match_class(r.req_size);
                if (c < 0)
                    g.status = tcsa_pkg::STAT_NOMATCH;
                else if (free_slots[c] == 0)
                    g.status = tcsa_pkg::STAT_EMPTY;
                else
                begin
                    free_slots[c]--;
                    g.addr = stack_mem[c][free_slots[c]];
                end
            end
            tcsa_pkg::OP_FREE:
            begin
                c = match_class(r.req_size);
                if (c < 0)
                    g.status = tcsa_pkg::STAT_NOMATCH;
                else if (free_slots[c] >= slot_limit(c))
                    g.status = tcsa_pkg::STAT_FULL;
                else
                begin
                    stack_mem[c][free_slots[c]] = r.slot_addr;
                    free_slots[c]++;
                end
            end
            tcsa_pkg::OP_REBUILD:
            begin
                a = base_reg;
                for (int k = 0; k < tcsa_pkg::NUM_CLASSES; k++)
                begin
                    for (int i = 0; i < slot_limit(k); i++)
                    begin
                        stack_mem[k][i] = a;
                        a = a + {16'd0, class_size[k]};
                    end
                    free_slots[k] = slot_limit(k);
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        slot_request_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.slot_addr, nxt.req_size};
                s_tuser  <= nxt.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results, then predict newly accepted items
    always @(posedge clk)
    begin : monitor
        slot_grant_t   want;
        slot_request_t got_req;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (grant_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result addr %h status %0d",
                                              m_tdata, m_tuser));
                else
                begin
                    want = grant_queue.pop_front();
                    if (m_tdata !== want.addr)
                        report_mismatch($sformatf("granted_address %h, expected %h",
                                                  m_tdata, want.addr));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                got_req.op        = s_tuser;
                got_req.req_size  = s_tdata[47:0];
                got_req.slot_addr = s_tdata[95:48];
                grant_queue.push_back(apply_request(got_req));
            end
        end
    end

    task automatic add_item(tcsa_pkg::opcode_t op, logic [47:0] req_size,
                            logic [47:0] slot_addr);
        slot_request_t r;
        r.op        = op;
        r.req_size  = req_size;
        r.slot_addr = slot_addr;
        request_queue.push_back(r);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        while (request_queue.size() != 0 || s_tvalid || grant_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(tcsa_pkg::cfg_index_t idx, logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            tcsa_pkg::REG_BASE:         base_reg                          = val;
            tcsa_pkg::REG_LARGE_SIZE:   class_size[tcsa_pkg::CLS_LARGE]   = val[31:0];
            tcsa_pkg::REG_LARGE_COUNT:  class_count[tcsa_pkg::CLS_LARGE]  = val[9:0];
            tcsa_pkg::REG_MEDIUM_SIZE:  class_size[tcsa_pkg::CLS_MEDIUM]  = val[31:0];
            tcsa_pkg::REG_MEDIUM_COUNT: class_count[tcsa_pkg::CLS_MEDIUM] = val[9:0];
            tcsa_pkg::REG_SMALL_SIZE:   class_size[tcsa_pkg::CLS_SMALL]   = val[31:0];
            tcsa_pkg::REG_SMALL_COUNT:  class_count[tcsa_pkg::CLS_SMALL]  = val[9:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [47:0] base, logic [31:0] ls, logic [9:0] lc,
                             logic [31:0] ms, logic [9:0] mc, logic [31:0] ss,
                             logic [9:0] sc);
        write_reg(tcsa_pkg::REG_BASE, base);
        write_reg(tcsa_pkg::REG_LARGE_SIZE, {16'd0, ls});
        write_reg(tcsa_pkg::REG_LARGE_COUNT, {38'd0, lc});
        write_reg(tcsa_pkg::REG_MEDIUM_SIZE, {16'd0, ms});
        write_reg(tcsa_pkg::REG_MEDIUM_COUNT, {38'd0, mc});
        write_reg(tcsa_pkg::REG_SMALL_SIZE, {16'd0, ss});
        write_reg(tcsa_pkg::REG_SMALL_COUNT, {38'd0, sc});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic logic [31:0] pick_slot_size(logic [31:0] prev);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return prev;
            3:       return 32'd1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [9:0] pick_count(int phase);
        if (phase == 0)
            return 10'd512;
        if (phase == 1)
            return 10'($urandom_range(1023, 513));
        if ($urandom_range(7) == 0)
            return 10'($urandom_range(1023));
        return 10'($urandom_range(10));
    endfunction

    initial
    begin : stimulus
        logic [47:0] base;
        logic [31:0] ls, ms, ss;
        logic [47:0] req;
        int          r;
        base_reg = '0;
        for (int c = 0; c < tcsa_pkg::NUM_CLASSES; c++)
        begin
            class_size[c]  = '0;
            class_count[c] = '0;
            free_slots[c]  = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: free before rebuild, empty, no match, no-op
        add_item(tcsa_pkg::OP_FREE, 48'd0, '1);
        add_item(tcsa_pkg::OP_ALLOC, 48'd0, 48'd0);
        add_item(tcsa_pkg::OP_ALLOC, '1, 48'd0);
        add_item(OP_NOP, '1, '1);
        add_item(tcsa_pkg::OP_REBUILD, 48'd0, 48'd0);
        add_item(tcsa_pkg::OP_ALLOC, 48'd0, 48'd0);
        wait_drain();

        // address wrap, equal medium/small sizes, small count above limit
        configure(48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 10'd3, 32'd4096, 10'd2, 32'd4096,
                  10'd1023);
        add_item(tcsa_pkg::OP_REBUILD, 48'd0, 48'd0);
        repeat (4) add_item(tcsa_pkg::OP_ALLOC, 48'hFFFF_FFFF, 48'd0);
        repeat (3) add_item(tcsa_pkg::OP_ALLOC, 48'd4096, 48'd0);
        add_item(tcsa_pkg::OP_FREE, 48'd4096, 48'd0);
        add_item(tcsa_pkg::OP_FREE, 48'd4096, '1);
        add_item(tcsa_pkg::OP_FREE, 48'd4096, 48'h1234_5678_9ABC);
        add_item(tcsa_pkg::OP_ALLOC, 48'd4096, 48'd0);
        add_item(tcsa_pkg::OP_FREE, 48'hFFFF_FFFF, 48'd1);
        add_item(tcsa_pkg::OP_FREE, 48'd1, 48'd0);
        wait_drain();

        // count lowered after rebuild
        write_reg(tcsa_pkg::REG_MEDIUM_COUNT, 48'd1);
        @(posedge clk);
        cfg_we <= 1'b0;
        add_item(tcsa_pkg::OP_FREE, 48'd4096, 48'hABC);
        add_item(tcsa_pkg::OP_ALLOC, 48'd4096, 48'd0);
        add_item(tcsa_pkg::OP_ALLOC, 48'd4096, 48'd0);
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            r    = $urandom_range(3);
            base = (r == 0) ? 48'd0 : (r == 1) ? '1 : rand48();
            ls   = pick_slot_size($urandom());
            ms   = pick_slot_size(ls);
            ss   = pick_slot_size(ms);
            configure(base, ls, pick_count(p), ms, pick_count(p), ss, pick_count(p));
            send_idle_pct = (p == 5) ? 0 : 26;
            recv_idle_pct = (p == 5) ? 0 : 26;
            if (p < 2 || $urandom_range(4) < 3)
                add_item(tcsa_pkg::OP_REBUILD, rand48(), rand48());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && (p == 2 || $urandom_range(2) == 0))
                    wait_drain();
                req = ($urandom_range(99) < 88) ? {16'd0, class_size[$urandom_range(2)]}
                                                : rand48();
                r = $urandom_range(99);
                if (r < 2)
                    add_item(tcsa_pkg::OP_REBUILD, req, rand48());
                else if (r < 4)
                    add_item(OP_NOP, req, rand48());
                else if (r < 52)
                    add_item(tcsa_pkg::OP_ALLOC, req, rand48());
                else
                    add_item(tcsa_pkg::OP_FREE, req, rand48());
            end
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (grant_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grant_queue.size()));
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tcsa_pkg.sv
hw/rtl/three_class_slot_allocator_top.sv
test/three_class_slot_allocator_top_test.sv
